@@ rtl/core/button_debounce_double_tap_core_assert.svh @@
// Assertion helpers for the debounce core; expect i_clk and i_rst_n in scope.
`ifndef BUTTON_DEBOUNCE_DOUBLE_TAP_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_DOUBLE_TAP_CORE_ASSERT_SVH

// Same-cycle implication.
`define BDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bdt_pkg.sv @@
`timescale 1ns / 1ps
package bdt_pkg;

    localparam int BUTTON_COUNT_DEF = 5;
    localparam int LEVEL_W          = 5;
    localparam int CNT_W            = 4;
    localparam int WINDOW_W         = 16;
    localparam int TIME_W           = 32;
    localparam int IDX_W            = 3;
    localparam int CMD_W            = 2;
    localparam int EV_W             = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DCHECK = 2'd2;

    localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_PUSHED   = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_POLLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LEVELS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_BUTTON     = 2'd3;

    localparam logic [CNT_W-1:0]    REQUIRED_POLLS_RST = 4'd3;
    localparam logic [WINDOW_W-1:0] TAP_WINDOW_MS_RST  = 16'd300;
    localparam logic [LEVEL_W-1:0]  NORMAL_LEVELS_RST  = 5'd20;
    localparam logic [IDX_W-1:0]    TAP_BUTTON_RST     = 3'd1;
    localparam logic [CNT_W-1:0]    CNT_MAX            = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LEVEL_W-1:0] raw_levels;
        logic [IDX_W-1:0]   button_index;
        logic [TIME_W-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic [EV_W-1:0]    button_event;
        logic               double_press;
        logic [LEVEL_W-1:0] confirmed_levels;
    } t_out_item;

endpackage

@@ rtl/core/bdt_in_if.sv @@
`timescale 1ns / 1ps
interface bdt_in_if;
    logic              valid;
    logic              ready;
    bdt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bdt_out_if.sv @@
`timescale 1ns / 1ps
interface bdt_out_if;
    logic               valid;
    logic               ready;
    bdt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bdt_cfg_if.sv @@
`timescale 1ns / 1ps
interface bdt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bdt_pkg::CFG_IDX_W-1:0]      index;
    logic [bdt_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/button_debounce_double_tap_core.sv @@
`timescale 1ns / 1ps
// Button debouncer with double-press detection.
// i_in carries one command per transaction: poll (all raw pin levels), check
// (report and clear the change flag of button_index) or double-check (same for
// the tap button, plus double-press timing on now_ms). Every transaction gives
// exactly one result transaction on o_out: event, double-press flag and the
// debounced levels after the command.
// i_cfg writes the four settings (index 0 required polls, 1 tap window in ms,
// 2 released pin levels, 3 tap button); it is always ready and should only be
// used while no command is in flight.
// The result is registered in the output register. All per-button state updates
// when the command is accepted, so one command per cycle is sustained while
// o_out accepts every result.
// The result side is an output register with a one-entry skid stage: a
// stalled receiver holds the current result while one more command is taken,
// after which i_in.ready drops until o_out accepts the held result.
// Reset (synchronous, active low) restores default settings, sets the
// debounced levels to the default released levels, clears counters, change
// flags and the tap arm, and empties the output stages.
module button_debounce_double_tap_core #(
    parameter int BUTTON_COUNT = bdt_pkg::BUTTON_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdt_in_if.sink    i_in,
    bdt_out_if.source o_out,
    bdt_cfg_if.sink   i_cfg
);

    `include "button_debounce_double_tap_core_assert.svh"

    localparam int CNT_W = bdt_pkg::CNT_W;
    localparam int LVL_W = bdt_pkg::LEVEL_W;

    // settings
    logic [CNT_W-1:0]             r_req_polls;
    logic [bdt_pkg::WINDOW_W-1:0] r_window;
    logic [LVL_W-1:0]             r_normal;
    logic [bdt_pkg::IDX_W-1:0]    r_tap_button;

    // debounce state
    logic [BUTTON_COUNT-1:0]      r_level,   n_level;
    logic [BUTTON_COUNT-1:0]      r_pending, n_pending;
    logic [CNT_W-1:0]             r_count [BUTTON_COUNT];
    logic [CNT_W-1:0]             n_count [BUTTON_COUNT];
    logic                         r_tap_armed, n_tap_armed;
    logic [bdt_pkg::TIME_W-1:0]   r_first_tap, n_first_tap;

    // output register and skid stage
    logic                         r_out_valid, r_skid_valid;
    bdt_pkg::t_out_item           r_out_data, r_skid_data;
    bdt_pkg::t_out_item           n_res;

    logic [BUTTON_COUNT-1:0]      raw_ext, normal_ext, rst_level, hit;
    logic [CNT_W-1:0]             need;
    logic [CNT_W-1:0]             inc;
    logic [bdt_pkg::IDX_W-1:0]    sel;
    logic [bdt_pkg::TIME_W-1:0]   gap;
    logic                         is_check, pending_hit, level_hit, normal_hit, in_window;
    logic                         accept, pop;

    // Buttons above the field width read raw and released levels as zero.
    genvar g;
    generate
        for (g = 0; g < BUTTON_COUNT; g++) begin : g_ext
            if (g < LVL_W) begin : g_in
                assign raw_ext[g]    = i_in.data.raw_levels[g];
                assign normal_ext[g] = r_normal[g];
                assign rst_level[g]  = bdt_pkg::NORMAL_LEVELS_RST[g];
            end else begin : g_zero
                assign raw_ext[g]    = 1'b0;
                assign normal_ext[g] = 1'b0;
                assign rst_level[g]  = 1'b0;
            end
        end
    endgenerate

    assign accept      = i_in.valid && i_in.ready;
    assign pop         = r_out_valid && o_out.ready;
    assign i_in.ready  = !r_skid_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;
    assign i_cfg.ready = 1'b1;

    assign need     = (r_req_polls == '0) ? CNT_W'(1) : r_req_polls;
    assign is_check = (i_in.data.command == bdt_pkg::CMD_CHECK) ||
                      (i_in.data.command == bdt_pkg::CMD_DCHECK);
    assign sel      = (i_in.data.command == bdt_pkg::CMD_CHECK) ? i_in.data.button_index
                                                               : r_tap_button;
    assign gap       = i_in.data.now_ms - r_first_tap;
    assign in_window = gap <= {{(bdt_pkg::TIME_W - bdt_pkg::WINDOW_W){1'b0}}, r_window};

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            hit[i] = (int'(sel) == i);
        end
    end

    // Out-of-range selections give an all-zero hit mask, so nothing is seen or cleared.
    assign pending_hit = |(r_pending & hit);
    assign level_hit   = |(r_level & hit);
    assign normal_hit  = |(normal_ext & hit);

    always_comb begin
        n_level     = r_level;
        n_pending   = r_pending;
        n_tap_armed = r_tap_armed;
        n_first_tap = r_first_tap;
        inc         = '0;
        n_res.button_event = bdt_pkg::EV_NONE;
        n_res.double_press = 1'b0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_count[i] = r_count[i];
        end

        if (i_in.data.command == bdt_pkg::CMD_POLL) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                if (raw_ext[i] != r_level[i]) begin
                    inc = (r_count[i] == bdt_pkg::CNT_MAX) ? bdt_pkg::CNT_MAX
                                                           : r_count[i] + CNT_W'(1);
                    if (inc >= need) begin
                        n_level[i]   = raw_ext[i];
                        n_pending[i] = 1'b1;
                        n_count[i]   = '0;
                    end else begin
                        n_count[i] = inc;
                    end
                end else begin
                    n_count[i] = '0;
                end
            end
        end else if (is_check) begin
            if (pending_hit) begin
                n_pending = r_pending & ~hit;
                n_res.button_event = (level_hit == normal_hit) ? bdt_pkg::EV_RELEASED
                                                               : bdt_pkg::EV_PUSHED;
            end
            if (i_in.data.command == bdt_pkg::CMD_DCHECK) begin
                if (n_res.button_event == bdt_pkg::EV_PUSHED) begin
                    if (r_tap_armed && in_window) begin
                        n_tap_armed        = 1'b0;
                        n_res.double_press = 1'b1;
                    end else begin
                        n_tap_armed = 1'b1;
                        n_first_tap = i_in.data.now_ms;
                    end
                end else if (r_tap_armed && !in_window) begin
                    n_tap_armed = 1'b0;
                end
            end
        end
        // buttons above the field width do not show in the levels word
        n_res.confirmed_levels = '0;
        for (int i = 0; i < BUTTON_COUNT && i < LVL_W; i++) begin
            n_res.confirmed_levels[i] = n_level[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_polls  <= bdt_pkg::REQUIRED_POLLS_RST;
            r_window     <= bdt_pkg::TAP_WINDOW_MS_RST;
            r_normal     <= bdt_pkg::NORMAL_LEVELS_RST;
            r_tap_button <= bdt_pkg::TAP_BUTTON_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bdt_pkg::CFG_REQUIRED_POLLS: r_req_polls  <= i_cfg.data[CNT_W-1:0];
                bdt_pkg::CFG_TAP_WINDOW_MS:  r_window     <= i_cfg.data[bdt_pkg::WINDOW_W-1:0];
                bdt_pkg::CFG_NORMAL_LEVELS:  r_normal     <= i_cfg.data[LVL_W-1:0];
                bdt_pkg::CFG_TAP_BUTTON:     r_tap_button <= i_cfg.data[bdt_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= rst_level;
            r_pending   <= '0;
            r_tap_armed <= 1'b0;
            r_first_tap <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_count[i] <= '0;
            end
        end else if (accept) begin
            r_level     <= n_level;
            r_pending   <= n_pending;
            r_tap_armed <= n_tap_armed;
            r_first_tap <= n_first_tap;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

    // Skid is only filled while the output register is held; ready is low while it is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else if ((pop || !r_out_valid) && accept) begin
            r_out_data <= n_res;
        end
        if (accept && r_out_valid && !pop) begin
            r_skid_data <= n_res;
        end
    end

    `BDT_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid stage holds a result while the output register is empty")
    `BDT_ASSERT_NOW(a_double_is_push, o_out.valid && o_out.data.double_press,
        o_out.data.button_event == bdt_pkg::EV_PUSHED,
        "double press reported without a push event")
    `BDT_ASSERT_NEXT(a_double_disarms, accept && n_res.double_press, !r_tap_armed,
        "tap arm still set after a double press")
    `BDT_ASSERT_NEXT(a_poll_keeps_flags, accept && i_in.data.command == bdt_pkg::CMD_POLL,
        ($past(r_pending) & ~r_pending) == '0,
        "poll cleared a change flag")

endmodule
